@@ sv/crfp_pkg.sv @@
// Shared types and constants for the checked range frame parser.
package crfp_pkg;

    localparam int unsigned FRAME_BYTES_DEFAULT = 16;
    localparam int unsigned COUNT_W = 6;

    localparam logic [7:0]  HDR_FIRST  = 8'h52;
    localparam logic [7:0]  HDR_SECOND = 8'h41;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    // Parser phase; the unused code is handled as hunting.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_WAIT2   = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

endpackage

@@ sv/checked_range_frame_parser_core.sv @@
// Top level of the checked range frame parser: header hunt, CRC check and result register.
//
// Usage: received bytes enter on the s_ channel, one byte per beat. The
// parser hunts for the header byte 0x52, then drops bytes until 0x41 arrives,
// and then collects the rest of a frame of FRAME_BYTES bytes. A reflected
// CRC-16 (init 0xFFFF, final inversion) covers all bytes but the last two,
// which must carry the CRC low byte first. On the last byte of a frame one
// beat leaves on the m_ channel with the big-endian distance from bytes 4
// and 5 and a CRC-good flag; on a CRC error the distance reads as zero and
// the frame is dropped. Other bytes produce no output beat.
// Every byte is handled in the cycle it is accepted, so one byte is taken
// every cycle unless a closing byte is held back, and a result appears on
// m_ in the cycle after the closing byte is accepted. The byte path is one
// CRC byte update (eight bit steps) before the state and result registers.
// Reset: aresetn (synchronous, active low) returns the parser to hunting and
// empties the result register. Stall: while a result waits for m_ready,
// bytes keep flowing as long as they produce no result; only a byte that
// would close a frame into a full, stalled result register is held back.
module checked_range_frame_parser_core
    import crfp_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_range_cm,
    output logic        m_crc_good
);

    localparam logic [COUNT_W-1:0] IDX_CRC_LO = COUNT_W'(FRAME_BYTES - 2);
    localparam logic [COUNT_W-1:0] IDX_DIST_HI = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] IDX_DIST_LO = COUNT_W'(5);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          dist_high_reg, dist_high_next;
    logic [7:0]          dist_low_reg, dist_low_next;
    logic                crc_low_match_reg, crc_low_match_next;

    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_range_cm_reg, m_range_cm_next;
    logic                m_crc_good_reg, m_crc_good_next;

    logic                accept;
    logic                closes_frame;
    logic [15:0]         crc_seed;
    logic [15:0]         crc_fed;
    logic [15:0]         crc_final;
    logic                frame_good;

    // A byte that closes a frame needs room in the result register; all other
    // bytes are taken unconditionally.
    assign closes_frame = (phase_reg == PH_COLLECT) && (byte_count_reg > IDX_CRC_LO);
    assign s_ready      = !closes_frame || !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;

    // While hunting, the header byte restarts the CRC from its initial value.
    assign crc_seed  = (phase_reg == PH_COLLECT || phase_reg == PH_WAIT2) ? crc_reg : CRC_INIT;
    assign crc_final = ~crc_reg;
    assign frame_good = crc_low_match_reg && (s_rx_byte == crc_final[15:8]);

    crfp_crc16_byte u_crc (
        .crc_in  (crc_seed),
        .data_in (s_rx_byte),
        .crc_out (crc_fed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            byte_count_reg    <= '0;
            crc_reg           <= CRC_INIT;
            crc_low_match_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            crc_reg           <= crc_next;
            crc_low_match_reg <= crc_low_match_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_high_reg     <= dist_high_next;
        dist_low_reg      <= dist_low_next;
        m_range_cm_reg    <= m_range_cm_next;
        m_crc_good_reg    <= m_crc_good_next;
    end

    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        crc_next           = crc_reg;
        dist_high_next     = dist_high_reg;
        dist_low_next      = dist_low_reg;
        crc_low_match_next = crc_low_match_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_range_cm_next    = m_range_cm_reg;
        m_crc_good_next    = m_crc_good_reg;

        if (accept) begin
            case (phase_reg)
                PH_WAIT2: begin
                    if (s_rx_byte == HDR_SECOND) begin
                        crc_next        = crc_fed;
                        byte_count_next = COUNT_W'(2);
                        phase_next      = PH_COLLECT;
                    end
                end
                PH_COLLECT: begin
                    if (byte_count_reg < IDX_CRC_LO) begin
                        crc_next        = crc_fed;
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                        if (byte_count_reg == IDX_DIST_HI) begin
                            dist_high_next = s_rx_byte;
                        end
                        if (byte_count_reg == IDX_DIST_LO) begin
                            dist_low_next = s_rx_byte;
                        end
                    end else if (byte_count_reg == IDX_CRC_LO) begin
                        crc_low_match_next = (s_rx_byte == crc_final[7:0]);
                        byte_count_next    = byte_count_reg + COUNT_W'(1);
                    end else begin
                        // Closing byte: emit the result and go back to hunting.
                        m_valid_next       = 1'b1;
                        m_crc_good_next    = frame_good;
                        m_range_cm_next    = frame_good ? {dist_high_reg, dist_low_reg}
                                                        : 16'h0000;
                        phase_next         = PH_HUNT;
                        byte_count_next    = '0;
                        crc_next           = CRC_INIT;
                        crc_low_match_next = 1'b0;
                    end
                end
                default: begin
                    if (s_rx_byte == HDR_FIRST) begin
                        crc_next        = crc_fed;
                        byte_count_next = COUNT_W'(1);
                        phase_next      = PH_WAIT2;
                    end
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_range_cm = m_range_cm_reg;
    assign m_crc_good = m_crc_good_reg;

    // The byte count follows the phase: zero while hunting, one after the
    // first header byte, at least two while collecting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT |-> byte_count_reg == '0)
        else $error("byte count not cleared while hunting");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_WAIT2 |-> byte_count_reg == COUNT_W'(1))
        else $error("byte count wrong while waiting for second header byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COLLECT |->
            (byte_count_reg >= COUNT_W'(2) && byte_count_reg <= COUNT_W'(FRAME_BYTES - 1)))
        else $error("byte count out of frame range while collecting");

    // A failed frame never reports a distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_crc_good_reg |-> m_range_cm_reg == 16'h0000)
        else $error("distance reported on CRC error");

    // Input back-pressure only arises from a stalled, full result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && closes_frame))
        else $error("input stalled without a pending result");

endmodule

@@ sv/crfp_crc16_byte.sv @@
// One-byte update of the reflected CRC-16 with polynomial 0x8408.
module crfp_crc16_byte
    import crfp_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

@@ sim/tb_checked_range_frame_parser_core.sv @@
// Testbench for the checked range frame parser: directed frames, random frames and a CRC predictor.
`timescale 1ns / 100ps

module tb_checked_range_frame_parser_core
    import crfp_pkg::*;
();

    // The directed table below is laid out for the default frame length.
    localparam int unsigned FRAME_LEN   = FRAME_BYTES_DEFAULT;
    localparam int          BYTE_TARGET = 1150;
    localparam int          CALM_TAIL   = 150;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DIR_ROWS    = 37;

    // One reading as it leaves the m_ channel.
    typedef struct packed {
        logic [15:0] range_cm;
        logic        crc_good;
    } reading_t;

    // How a directed row gets its byte: taken as written, or derived from the
    // CRC that the predictor holds at that moment, xored with the written value
    // (so a nonzero value corrupts the check byte on purpose).
    typedef enum logic [1:0] {
        BYTE_LIT    = 2'd0,
        BYTE_CRC_LO = 2'd1,
        BYTE_CRC_HI = 2'd2
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  value;
        logic        typed;
        logic [15:0] typed_distance;
        logic        typed_good;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_range_cm;
    logic        m_crc_good;

    // Parser state as the predictor sees it.
    phase_t      pred_phase = PH_HUNT;
    logic [5:0]  pred_count = '0;
    logic [15:0] pred_crc = CRC_INIT;
    logic [7:0]  pred_dist_hi = '0;
    logic [7:0]  pred_dist_lo = '0;
    logic        pred_lo_ok = 1'b0;

    reading_t    readings_due[$];
    int          used_bytes = 0;
    int          idle_rate = 0;
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // Directed frames. The first frame walks the hunt rules (noise, a second
    // header byte while waiting, a stray 0x41 while hunting) and carries the
    // largest distance with a correct CRC. The second has its low CRC byte
    // corrupted, so its reading must come back as zero with the flag clear.
    // Data bytes equal to the header codes sit inside the frames on purpose.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{BYTE_LIT,    8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h41, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h52, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h52, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h41, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h55, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hAA, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h41, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h52, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h01, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h80, 1'b0, 16'h0000, 1'b0},
        '{BYTE_CRC_LO, 8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_CRC_HI, 8'h00, 1'b1, 16'hFFFF, 1'b1},
        '{BYTE_LIT,    8'h52, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h41, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h5A, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hA5, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h12, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h34, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h80, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h01, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFE, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h7F, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h00, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hFF, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'hC3, 1'b0, 16'h0000, 1'b0},
        '{BYTE_LIT,    8'h3C, 1'b0, 16'h0000, 1'b0},
        '{BYTE_CRC_LO, 8'h01, 1'b0, 16'h0000, 1'b0},
        '{BYTE_CRC_HI, 8'h00, 1'b1, 16'h0000, 1'b0}
    };

    checked_range_frame_parser_core #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_range_cm   (m_range_cm),
        .m_crc_good   (m_crc_good)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a reading that never shows up ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One byte through the reflected CRC-16 register, LSB first.
    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] x;
        x = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // Half of the finished CRC that the frame should carry next.
    function automatic logic [7:0] crc_check_half(bit high_half);
        logic [15:0] fin;
        fin = pred_crc ^ 16'hFFFF;
        return high_half ? fin[15:8] : fin[7:0];
    endfunction

    function automatic void parser_clear();
        pred_phase   = PH_HUNT;
        pred_count   = '0;
        pred_crc     = CRC_INIT;
        pred_dist_hi = '0;
        pred_dist_lo = '0;
        pred_lo_ok   = 1'b0;
    endfunction

    // Predicts what one accepted byte does to the parser. used is cleared for
    // bytes the hunt drops; closed is set when the byte ends a frame.
    task automatic frame_parse(input logic [7:0] b, output bit used, output bit closed,
                               output reading_t r);
        logic [5:0]  idx;
        logic [15:0] fin;
        used   = 1'b1;
        closed = 1'b0;
        r      = '0;
        idx    = pred_count;
        fin    = pred_crc ^ 16'hFFFF;
        if (pred_phase == PH_WAIT2) begin
            // Anything but the second header byte is dropped, a new 0x52 too.
            if (b == HDR_SECOND) begin
                pred_crc   = crc_step(pred_crc, b);
                pred_count = 6'd2;
                pred_phase = PH_COLLECT;
            end else begin
                used = 1'b0;
            end
        end else if (pred_phase != PH_COLLECT) begin
            if (b == HDR_FIRST) begin
                pred_crc   = crc_step(CRC_INIT, b);
                pred_count = 6'd1;
                pred_phase = PH_WAIT2;
            end else begin
                used = 1'b0;
            end
        end else if (idx < FRAME_LEN - 2) begin
            pred_crc = crc_step(pred_crc, b);
            if (idx == 6'd4) begin
                pred_dist_hi = b;
            end
            if (idx == 6'd5) begin
                pred_dist_lo = b;
            end
            pred_count = idx + 6'd1;
        end else if (idx == FRAME_LEN - 2) begin
            pred_lo_ok = (b == fin[7:0]);
            pred_count = idx + 6'd1;
        end else begin
            // Closing byte: a CRC failure reports zero distance and drops the frame.
            closed = 1'b1;
            if (pred_lo_ok && b == fin[15:8]) begin
                r.range_cm = {pred_dist_hi, pred_dist_lo};
                r.crc_good = 1'b1;
            end
            parser_clear();
        end
    endtask

    // Offers one byte on the s_ channel, holding it until accepted, then runs
    // the predictor. Before the beat the sender may go quiet for a burst. A
    // typed expectation, where given, replaces the predicted one.
    task automatic send_byte(input logic [7:0] b, input bit typed, input reading_t typed_r);
        bit       used;
        bit       closed;
        reading_t r;
        int       gap;
        if (!calm && idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        frame_parse(b, used, closed, r);
        if (typed) begin
            readings_due.push_back(typed_r);
        end else if (closed) begin
            readings_due.push_back(r);
        end
        if (used) begin
            used_bytes++;
        end
        if (used_bytes >= BYTE_TARGET - CALM_TAIL) begin
            calm = 1'b1;
        end
    endtask

    // Body bytes lean toward the extremes now and then.
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One random stretch of traffic: mostly well-formed frames with random
    // content and an occasional bad CRC, plus loose noise and frames cut short.
    task automatic send_random_frame();
        int         shape;
        int         stop;
        int         fault;
        logic [7:0] b;
        logic [7:0] flip;
        shape = $urandom_range(0, 15);
        fault = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       idle_rate = 0;
                1:       idle_rate = 3;
                default: idle_rate = 12;
            endcase
        end
        if (shape < 2) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0, '0);
        end else begin
            stop = (shape == 2) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
            for (int p = 0; p < stop; p++) begin
                // Sometimes junk arrives between the two header bytes.
                if (p == 1 && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom);
                        if (b == HDR_SECOND || $urandom_range(0, 3) == 0) begin
                            b = HDR_FIRST;
                        end
                        send_byte(b, 1'b0, '0);
                    end
                end
                flip = 8'($urandom_range(1, 255));
                if (p == 0) begin
                    b = HDR_FIRST;
                end else if (p == 1) begin
                    b = HDR_SECOND;
                end else if (p < FRAME_LEN - 2) begin
                    b = body_byte();
                end else if (p == FRAME_LEN - 2) begin
                    b = crc_check_half(1'b0) ^ ((fault == 0 || fault == 2) ? flip : 8'h00);
                end else begin
                    b = crc_check_half(1'b1) ^ ((fault == 1 || fault == 2) ? flip : 8'h00);
                end
                send_byte(b, 1'b0, '0);
            end
        end
    endtask

    // Receiver: long ready stretches broken by stall bursts, none in the tail.
    initial begin
        int len;
        bit stall;
        forever begin
            stall = !calm && $urandom_range(0, 2) == 0;
            len   = stall ? $urandom_range(1, 17) : $urandom_range(1, 60);
            @(negedge aclk);
            m_ready <= !stall;
            repeat (len - 1) @(negedge aclk);
        end
    end

    // Reading checker: every beat on m_ is matched against the oldest expectation.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                $error("unexpected reading: range_cm %h crc_good %b",
                       m_range_cm, m_crc_good);
                mismatches++;
            end else begin
                want = readings_due.pop_front();
                if (m_range_cm !== want.range_cm) begin
                    $error("range_cm: expected %h, got %h", want.range_cm, m_range_cm);
                    mismatches++;
                end
                if (m_crc_good !== want.crc_good) begin
                    $error("crc_good: expected %b, got %b", want.crc_good, m_crc_good);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random frames, drain.
    initial begin
        logic [7:0] b;
        reading_t   typed_r;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_rate = 4;
        for (int i = 0; i < DIR_ROWS; i++) begin
            case (directed_rows[i].kind)
                BYTE_CRC_LO: b = crc_check_half(1'b0) ^ directed_rows[i].value;
                BYTE_CRC_HI: b = crc_check_half(1'b1) ^ directed_rows[i].value;
                default:     b = directed_rows[i].value;
            endcase
            typed_r.range_cm = directed_rows[i].typed_distance;
            typed_r.crc_good = directed_rows[i].typed_good;
            send_byte(b, directed_rows[i].typed, typed_r);
        end

        while (used_bytes < BYTE_TARGET) begin
            send_random_frame();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every outstanding reading, then keep watching for strays.
        while (readings_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
